[rtl/core/fuzzy_name_alignment_score_macros.svh]
// Assertion macros for the fuzzy name alignment score block.
// Included by modules that check their own logic; no other dependencies.
`ifndef FUZZY_NAME_ALIGNMENT_SCORE_MACROS_SVH
`define FUZZY_NAME_ALIGNMENT_SCORE_MACROS_SVH
`ifndef SYNTHESIS
`define FNAS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fnas assertion failed");
`define FNAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fnas assertion failed");
`else
`define FNAS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define FNAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/fnas_pkg.sv]
// Shared types, constants and score arithmetic for the alignment chain.
// No dependencies.
package fnas_pkg;

	localparam int SCORE_W = 6;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int LEN_REG_W = 5;
	localparam int QWORD_W = 64;

	localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
	localparam logic [SCORE_W-1:0] GAP_COST = SCORE_W'(2);
	localparam logic [SCORE_W-1:0] MATCH_GAIN = SCORE_W'(3);
	localparam logic [SCORE_W-1:0] MISMATCH_COST = SCORE_W'(3);

	localparam logic [CFG_IDX_W-1:0] REG_QUERY_LENGTH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_LOW = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_HIGH = CFG_IDX_W'(2);

	typedef logic [SCORE_W-1:0] score_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
		logic              last;
		score_t            up;
		score_t            diag;
		score_t            tail;
	} tok_t;

	function automatic score_t sub_floor(input score_t v, input score_t d);
		return (v > d) ? score_t'(v - d) : '0;
	endfunction

	function automatic score_t add_sat(input score_t v, input score_t d);
		logic [SCORE_W:0] s;
		s = {1'b0, v} + {1'b0, d};
		return s[SCORE_W] ? SCORE_MAX : s[SCORE_W-1:0];
	endfunction

endpackage

[rtl/core/fnas_if.sv]
// Channel interfaces: name byte stream, score result stream, config writes.
// Depends on fnas_pkg.
interface fnas_name_if;
	logic                           valid;
	logic                           ready;
	logic [fnas_pkg::BYTE_W-1:0]    name_byte;
	logic                           last_byte;
	modport source (output valid, name_byte, last_byte, input ready);
	modport sink (input valid, name_byte, last_byte, output ready);
endinterface

interface fnas_result_if;
	logic                           valid;
	logic                           ready;
	logic [fnas_pkg::SCORE_W-1:0]   score;
	logic                           name_too_short;
	modport source (output valid, score, name_too_short, input ready);
	modport sink (input valid, score, name_too_short, output ready);
endinterface

interface fnas_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [fnas_pkg::CFG_IDX_W-1:0] index;
	logic [fnas_pkg::QWORD_W-1:0]   data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/fnas_cell.sv]
// One alignment cell: holds the score of one query position, passes beats on.
// Depends on fnas_pkg.
module fnas_cell #(
	parameter int INDEX = 0,
	parameter int LEN_W = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [fnas_pkg::BYTE_W-1:0] query_byte,
	input  logic [LEN_W-1:0]            active_len,
	input  fnas_pkg::tok_t              tok_in,
	output fnas_pkg::tok_t              tok_out
);

	fnas_pkg::score_t score_q;
	fnas_pkg::score_t from_left;
	fnas_pkg::score_t from_up;
	fnas_pkg::score_t from_diag;
	fnas_pkg::score_t best;
	fnas_pkg::score_t next_score;
	logic             in_use;
	logic             is_tail;
	fnas_pkg::tok_t   tok_q;

	always_comb begin
		from_left = fnas_pkg::sub_floor(score_q, fnas_pkg::GAP_COST);
		from_up = fnas_pkg::sub_floor(tok_in.up, fnas_pkg::GAP_COST);
		if (query_byte == tok_in.data) begin
			from_diag = fnas_pkg::add_sat(tok_in.diag, fnas_pkg::MATCH_GAIN);
		end else begin
			from_diag = fnas_pkg::sub_floor(tok_in.diag, fnas_pkg::MISMATCH_COST);
		end
		best = (from_up > from_left) ? from_up : from_left;
		if (from_diag > best) begin
			best = from_diag;
		end
		in_use = LEN_W'(INDEX) < active_len;
		is_tail = LEN_W'(INDEX + 1) == active_len;
		next_score = in_use ? best : score_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
			tok_q <= '0;
		end else if (advance) begin
			tok_q.valid <= tok_in.valid;
			tok_q.data <= tok_in.data;
			tok_q.last <= tok_in.last;
			tok_q.up <= next_score;
			tok_q.diag <= score_q;
			tok_q.tail <= is_tail ? best : tok_in.tail;
			if (tok_in.valid) begin
				score_q <= tok_in.last ? '0 : next_score;
			end
		end
	end

	assign tok_out = tok_q;

endmodule

[rtl/core/fnas_collect.sv]
// Chain end: tracks best tail score and name length, holds the result beat.
// Depends on fnas_pkg and the assertion macro header.
`include "fuzzy_name_alignment_score_macros.svh"
module fnas_collect #(
	parameter int MAX_QUERY = 16,
	parameter int LEN_W = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fnas_pkg::tok_t               tok_in,
	input  logic [LEN_W-1:0]             active_len,
	output logic                         advance,
	input  logic                         res_ready,
	output logic                         res_valid,
	output logic [fnas_pkg::SCORE_W-1:0] res_score,
	output logic                         res_too_short
);

	fnas_pkg::score_t best_q;
	logic [LEN_W-1:0] len_q;
	fnas_pkg::score_t new_best;
	logic [LEN_W-1:0] new_len;
	logic             out_valid_q;
	fnas_pkg::score_t out_score_q;
	logic             out_short_q;
	logic             finish;

	assign advance = !out_valid_q || res_ready;
	assign finish = advance && tok_in.valid && tok_in.last;

	always_comb begin
		new_best = (tok_in.tail > best_q) ? tok_in.tail : best_q;
		new_len = (len_q < LEN_W'(MAX_QUERY)) ? LEN_W'(len_q + 1'b1) : len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
			len_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance && tok_in.valid) begin
				best_q <= tok_in.last ? '0 : new_best;
				len_q <= tok_in.last ? '0 : new_len;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_short_q <= new_len < active_len;
			out_score_q <= (new_len < active_len) ? '0 : new_best;
		end
	end

	assign res_valid = out_valid_q;
	assign res_score = out_score_q;
	assign res_too_short = out_short_q;

	`FNAS_ASSERT_IMPLY(a_short_zero, clk, arst_n, (out_valid_q && out_short_q), (out_score_q == '0))
	`FNAS_ASSERT_NEXT(a_clear_after_last, clk, arst_n, finish, ((best_q == '0) && (len_q == '0)))
	`FNAS_ASSERT_NEXT(a_result_after_last, clk, arst_n, finish, out_valid_q)
	`FNAS_ASSERT_IMPLY(a_len_bound, clk, arst_n, 1'b1, (len_q <= LEN_W'(MAX_QUERY)))

endmodule

[rtl/core/fuzzy_name_alignment_score.sv]
// Fuzzy name alignment score: top level, config registers and cell chain.
// Depends on fnas_pkg, fnas_if, fnas_cell and fnas_collect.
//
// Usage:
//   cfg         : register writes (0 query length, 1 query bytes 0-7,
//                 2 query bytes 8-15); always ready, write only when idle.
//   name_stream : one file-name byte per beat, last_byte marks the end.
//   result      : one beat per name, the best local alignment score that
//                 ends at the last query byte, or name_too_short with 0.
// Throughput: one name byte per cycle while no result waits unread; each beat walks
//   the row of MAX_QUERY cells, one query position per cell, with a register in each cell.
// Result path: the last byte passes each cell's register in turn, then the result register.
// Stall: while a result waits unread the whole chain holds and
//   name_stream.ready drops; nothing is lost.
// Reset: scores, best score and name length clear; query length reads 1,
//   query bytes read 0.
module fuzzy_name_alignment_score #(
	parameter int MAX_QUERY = 16
) (
	input logic           clk,
	input logic           arst_n,
	fnas_cfg_if.sink      cfg,
	fnas_name_if.sink     name_stream,
	fnas_result_if.source result
);

	localparam int LEN_W = $clog2(MAX_QUERY + 1);

	logic [fnas_pkg::LEN_REG_W-1:0] query_length_q;
	logic [fnas_pkg::QWORD_W-1:0]   query_low_q;
	logic [fnas_pkg::QWORD_W-1:0]   query_high_q;
	logic [LEN_W-1:0]               active_len;
	logic                           advance;
	fnas_pkg::tok_t                 tok [MAX_QUERY+1];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_length_q <= fnas_pkg::LEN_REG_W'(1);
			query_low_q <= '0;
			query_high_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fnas_pkg::REG_QUERY_LENGTH: begin
					query_length_q <= cfg.data[fnas_pkg::LEN_REG_W-1:0];
				end
				fnas_pkg::REG_QUERY_LOW: begin
					query_low_q <= cfg.data;
				end
				fnas_pkg::REG_QUERY_HIGH: begin
					query_high_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (query_length_q == '0) begin
			active_len = LEN_W'(1);
		end else if (int'(query_length_q) > MAX_QUERY) begin
			active_len = LEN_W'(MAX_QUERY);
		end else begin
			active_len = LEN_W'(query_length_q);
		end
	end

	assign name_stream.ready = advance;

	assign tok[0] = '{
		valid: name_stream.valid,
		data: name_stream.name_byte,
		last: name_stream.last_byte,
		up: '0,
		diag: '0,
		tail: '0
	};

	for (genvar g = 0; g < MAX_QUERY; g++) begin : g_cell
		logic [fnas_pkg::BYTE_W-1:0] qbyte;
		if (g < 8) begin : g_low
			assign qbyte = query_low_q[8*g +: 8];
		end else if (g < 16) begin : g_high
			assign qbyte = query_high_q[8*(g-8) +: 8];
		end else begin : g_none
			assign qbyte = '0;
		end
		fnas_cell #(
			.INDEX(g),
			.LEN_W(LEN_W)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.advance(advance),
			.query_byte(qbyte),
			.active_len(active_len),
			.tok_in(tok[g]),
			.tok_out(tok[g+1])
		);
	end

	fnas_collect #(
		.MAX_QUERY(MAX_QUERY),
		.LEN_W(LEN_W)
	) u_collect (
		.clk(clk),
		.arst_n(arst_n),
		.tok_in(tok[MAX_QUERY]),
		.active_len(active_len),
		.advance(advance),
		.res_ready(result.ready),
		.res_valid(result.valid),
		.res_score(result.score),
		.res_too_short(result.name_too_short)
	);

endmodule

[sim/fuzzy_name_alignment_score_test.sv]
// Testbench for the fuzzy name alignment score block: directed rows, then random names.
// Checks each score beat against a set value or a local-alignment predictor kept here.
// Depends on fnas_pkg, fnas_if and the fuzzy_name_alignment_score RTL.
module fuzzy_name_alignment_score_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_QUERY = 16;
	localparam int DRAIN_CYCLES = MAX_QUERY + 4;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [fnas_pkg::CFG_IDX_W-1:0] REG_SPARE = fnas_pkg::CFG_IDX_W'(3);

	typedef struct packed {
		fnas_pkg::score_t score;
		logic             too_short;
	} verdict_t;

	typedef enum logic { ROW_WRITE, ROW_BYTE } row_kind_t;

	typedef struct {
		row_kind_t                      kind;
		logic [fnas_pkg::CFG_IDX_W-1:0] index;
		logic [fnas_pkg::QWORD_W-1:0]   data;
		logic [fnas_pkg::BYTE_W-1:0]    name_byte;
		logic                           last_byte;
		bit                             typed;
		verdict_t                       want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	fnas_cfg_if    cfg_ch();
	fnas_name_if   name_ch();
	fnas_result_if score_ch();

	fuzzy_name_alignment_score #(.MAX_QUERY(MAX_QUERY)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_ch),
		.name_stream (name_ch),
		.result      (score_ch)
	);

	logic [4:0]                   query_len_reg;
	logic [fnas_pkg::QWORD_W-1:0] query_lo;
	logic [fnas_pkg::QWORD_W-1:0] query_hi;
	fnas_pkg::score_t             column [MAX_QUERY];
	fnas_pkg::score_t             best_tail;
	logic [4:0]                   bytes_seen;

	verdict_t    pending_scores[$];
	row_t        plan[$];
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned mismatches = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		score_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic int unsigned used_length();
		if (query_len_reg == 0)
			return 1;
		if (query_len_reg > MAX_QUERY)
			return MAX_QUERY;
		return 32'(query_len_reg);
	endfunction

	function automatic logic [fnas_pkg::BYTE_W-1:0] query_char(input int unsigned p);
		if (p < 8)
			return query_lo[8*p +: 8];
		return query_hi[8*(p-8) +: 8];
	endfunction

	function automatic void forget_name();
		foreach (column[i])
			column[i] = '0;
		best_tail = '0;
		bytes_seen = '0;
	endfunction

	task automatic score_name_byte(input logic [fnas_pkg::BYTE_W-1:0] b, input logic l,
		output bit emits, output verdict_t v);
		int unsigned n, i, diag, up, left, pick, d;
		n = used_length();
		diag = 0;
		up = 0;
		for (i = 0; i < n; i++) begin
			left = 32'(column[i]);
			pick = (left > 2) ? left - 2 : 0;
			if (up > 2 && up - 2 > pick)
				pick = up - 2;
			if (query_char(i) == b)
				d = (diag + 3 > 63) ? 63 : diag + 3;
			else
				d = (diag > 3) ? diag - 3 : 0;
			if (d > pick)
				pick = d;
			column[i] = fnas_pkg::score_t'(pick);
			diag = left;
			up = pick;
		end
		if (column[n-1] > best_tail)
			best_tail = column[n-1];
		if (bytes_seen < MAX_QUERY)
			bytes_seen++;
		emits = l;
		v = '0;
		if (l) begin
			if (bytes_seen < n)
				v.too_short = 1'b1;
			else
				v.score = best_tail;
			forget_name();
		end
	endtask

	task automatic note_failure(input string what, input verdict_t want, input verdict_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%s at %0t: expected score %0d short %0b, got score %0d short %0b",
				what, $realtime, want.score, want.too_short, got.score, got.too_short);
	endtask

	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n && score_ch.valid && score_ch.ready) begin
			got.score = score_ch.score;
			got.too_short = score_ch.name_too_short;
			if (pending_scores.size() == 0) begin
				note_failure("unexpected score beat", '0, got);
			end else begin
				want = pending_scores.pop_front();
				if (got.score !== want.score || got.too_short !== want.too_short)
					note_failure("score mismatch", want, got);
			end
		end
	end

	task automatic send_byte(input logic [fnas_pkg::BYTE_W-1:0] b, input logic l,
		input bit typed, input verdict_t want);
		bit emits;
		verdict_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			name_ch.valid <= 1'b0;
			@(posedge clk);
		end
		name_ch.valid <= 1'b1;
		name_ch.name_byte <= b;
		name_ch.last_byte <= l;
		do @(posedge clk); while (!name_ch.ready);
		score_name_byte(b, l, emits, got);
		if (emits)
			pending_scores.push_back(typed ? want : got);
	endtask

	// hold until every score is back, then let bytes in flight clear the chain
	task automatic drain();
		name_ch.valid <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fnas_pkg::CFG_IDX_W-1:0] idx,
		input logic [fnas_pkg::QWORD_W-1:0] value, input bit hold);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (!hold)
			cfg_ch.valid <= 1'b0;
		case (idx)
			fnas_pkg::REG_QUERY_LENGTH: query_len_reg = value[4:0];
			fnas_pkg::REG_QUERY_LOW:    query_lo = value;
			fnas_pkg::REG_QUERY_HIGH:   query_hi = value;
			default:                    ;
		endcase
	endtask

	task automatic load_query(input logic [4:0] len, input logic [fnas_pkg::QWORD_W-1:0] lo,
		input logic [fnas_pkg::QWORD_W-1:0] hi);
		drain();
		write_reg(fnas_pkg::REG_QUERY_LENGTH, fnas_pkg::QWORD_W'(len), 1'b1);
		write_reg(fnas_pkg::REG_QUERY_LOW, lo, 1'b1);
		write_reg(fnas_pkg::REG_QUERY_HIGH, hi, 1'b0);
	endtask

	function automatic logic [fnas_pkg::QWORD_W-1:0] pick_query_word(input bit narrow,
		input logic [fnas_pkg::BYTE_W-1:0] base);
		logic [fnas_pkg::QWORD_W-1:0] w;
		if (!narrow)
			return {$urandom, $urandom};
		for (int i = 0; i < 8; i++)
			w[8*i +: 8] = base + fnas_pkg::BYTE_W'($urandom_range(3, 0));
		return w;
	endfunction

	// mostly names that follow the query with random edits, the rest plain noise
	task automatic play_names(input int budget);
		int sent, len, n, k, i;
		bit tidy;
		logic [fnas_pkg::BYTE_W-1:0] b;
		sent = 0;
		while (sent < budget) begin
			n = used_length();
			tidy = ($urandom_range(99) < 80);
			if (tidy)
				len = $urandom_range(n + 4, (n > 3) ? n - 3 : 1);
			else
				len = $urandom_range(24, 1);
			k = 0;
			for (i = 0; i < len; i++) begin
				if (tidy && $urandom_range(99) < 75) begin
					b = query_char(k % n);
					k++;
				end else begin
					b = fnas_pkg::BYTE_W'($urandom_range(255, 0));
				end
				send_byte(b, i == len - 1, 1'b0, '0);
			end
			sent += len;
		end
	endtask

	function automatic row_t write_row(input logic [fnas_pkg::CFG_IDX_W-1:0] idx,
		input logic [fnas_pkg::QWORD_W-1:0] value);
		row_t r;
		r = '{ROW_WRITE, idx, value, '0, 1'b0, 1'b0, '0};
		return r;
	endfunction

	function automatic row_t byte_row(input logic [fnas_pkg::BYTE_W-1:0] b, input logic l);
		row_t r;
		r = '{ROW_BYTE, '0, '0, b, l, 1'b0, '0};
		return r;
	endfunction

	function automatic row_t checked_row(input logic [fnas_pkg::BYTE_W-1:0] b, input int s,
		input logic short);
		row_t r;
		r = '{ROW_BYTE, '0, '0, b, 1'b1, 1'b1, '{fnas_pkg::score_t'(s), short}};
		return r;
	endfunction

	task automatic build_plan();
		plan.push_back(checked_row(8'h00, 3, 1'b0));
		plan.push_back(checked_row(8'hFF, 0, 1'b0));
		plan.push_back(write_row(fnas_pkg::REG_QUERY_LENGTH, 64'd16));
		plan.push_back(write_row(fnas_pkg::REG_QUERY_LOW, '1));
		plan.push_back(write_row(fnas_pkg::REG_QUERY_HIGH, '1));
		plan.push_back(checked_row(8'hFF, 0, 1'b1));
		for (int i = 0; i < 15; i++)
			plan.push_back(byte_row(8'hFF, 1'b0));
		plan.push_back(checked_row(8'hFF, 48, 1'b0));
		plan.push_back(write_row(fnas_pkg::REG_QUERY_LENGTH, 64'd0));
		plan.push_back(write_row(fnas_pkg::REG_QUERY_LOW, 64'h41));
		plan.push_back(checked_row(8'h41, 3, 1'b0));
		plan.push_back(write_row(fnas_pkg::REG_QUERY_LENGTH, 64'd31));
		plan.push_back(checked_row(8'h41, 0, 1'b1));
		plan.push_back(write_row(REG_SPARE, 64'hA5A5_5A5A_F00F_0FF0));
		plan.push_back(write_row(fnas_pkg::REG_QUERY_LENGTH, 64'd2));
		plan.push_back(byte_row(8'h41, 1'b0));
		plan.push_back(write_row(fnas_pkg::REG_QUERY_LENGTH, 64'd1));
		plan.push_back(byte_row(8'h41, 1'b1));
	endtask

	int         idle_plan [4] = '{0, 54, 0, 20};
	int         stall_plan[4] = '{0, 0, 54, 20};
	logic [4:0] first_len [4] = '{5'd16, 5'd1, 5'd0, 5'd31};

	initial begin
		logic [4:0] len;
		logic [fnas_pkg::BYTE_W-1:0] base;
		bit narrow;
		arst_n <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		name_ch.valid <= 1'b0;
		name_ch.name_byte <= '0;
		name_ch.last_byte <= 1'b0;
		query_len_reg = 5'd1;
		query_lo = '0;
		query_hi = '0;
		forget_name();
		build_plan();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_WRITE) begin
				drain();
				write_reg(plan[r].index, plan[r].data, 1'b0);
			end else begin
				send_byte(plan[r].name_byte, plan[r].last_byte, plan[r].typed, plan[r].want);
			end
		end

		for (int ph = 0; ph < 4; ph++) begin
			for (int s = 0; s < 4; s++) begin
				case ($urandom_range(5, 0))
					0:       len = 5'd0;
					1:       len = 5'd1;
					2:       len = 5'd16;
					3:       len = 5'($urandom_range(31, 17));
					default: len = 5'($urandom_range(16, 1));
				endcase
				if (s == 0)
					len = first_len[ph];
				narrow = ($urandom_range(99) < 60);
				base = fnas_pkg::BYTE_W'($urandom);
				load_query(len, pick_query_word(narrow, base), pick_query_word(narrow, base));
				send_idle_pct = idle_plan[ph];
				stall_pct = stall_plan[ph];
				play_names(62);
			end
		end

		drain();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
